FILE: hdl/jlrc_pkg.sv
// Shared types, constants and helper functions for the journal lock reference counter.
package jlrc_pkg;

  // Sizing of the stores.
  localparam int MAX_LOCKS          = 256;
  localparam int MAX_LOGICAL_ZONES  = 8;
  localparam int MAX_PHYSICAL_ZONES = 8;
  localparam int MAX_ZONES          = (MAX_LOGICAL_ZONES > MAX_PHYSICAL_ZONES) ?
                                      MAX_LOGICAL_ZONES : MAX_PHYSICAL_ZONES;

  // Field and register widths.
  localparam int LOCK_IDX_W  = 8;
  localparam int ZONE_IDX_W  = 3;
  localparam int COUNT_W     = 16;
  localparam int HOLD_W      = 4;
  localparam int LOCK_CNT_W  = 9;
  localparam int ZONE_CNT_W  = 4;
  localparam int CMD_W       = 3;
  localparam int ERR_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  // Memory geometry: per-lock store and per-zone reference store (both kinds).
  localparam int LOCK_DEPTH  = MAX_LOCKS;
  localparam int LOCK_AW     = $clog2(LOCK_DEPTH);
  localparam int SLOT_W      = $clog2(MAX_LOCKS * MAX_ZONES);
  localparam int REF_DEPTH   = 2 * (2 ** SLOT_W);
  localparam int REF_AW      = SLOT_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT         = 3'd0,
    CMD_ACQUIRE      = 3'd1,
    CMD_RELEASE      = 3'd2,
    CMD_JRELEASE     = 3'd3,
    CMD_JRELEASE_OTH = 3'd4,
    CMD_ACK          = 3'd5
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 3'd0,
    ERR_OVERFLOW  = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_IN_USE    = 3'd3,
    ERR_RANGE     = 3'd4
  } err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCK_COUNT     = 2'd0,
    CFG_LOGICAL_ZONES  = 2'd1,
    CFG_PHYSICAL_ZONES = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [LOCK_IDX_W-1:0] lock_index;
    logic                  zone_kind;
    logic [ZONE_IDX_W-1:0] zone_index;
    logic [COUNT_W-1:0]    init_value;
  } in_t;

  typedef struct packed {
    logic             locked;
    logic             notify;
    logic [ERR_W-1:0] error;
  } out_t;

  typedef struct packed {
    logic [COUNT_W-1:0] jcount;
    logic [COUNT_W-1:0] jdec;
    logic [HOLD_W-1:0]  lhold;
    logic [HOLD_W-1:0]  phold;
  } lock_entry_t;

  typedef struct packed {
    logic               lock_we;
    logic               ref_we;
    lock_entry_t        lock_wdata;
    logic [COUNT_W-1:0] ref_wdata;
    logic               set_pending;
    logic               clr_pending;
    out_t               result;
  } upd_t;

  // Lock count in use, limited to the size of the store.
  function automatic logic [LOCK_CNT_W-1:0] eff_locks(input logic [LOCK_CNT_W-1:0] cnt);
    logic [LOCK_CNT_W-1:0] lim;
    lim = LOCK_CNT_W'(MAX_LOCKS);
    return (cnt > lim) ? lim : cnt;
  endfunction

  // Zone count in use for the given kind, limited to the size of the store.
  function automatic logic [ZONE_CNT_W-1:0] eff_zones(input logic                  kind,
                                                      input logic [ZONE_CNT_W-1:0] lcnt,
                                                      input logic [ZONE_CNT_W-1:0] pcnt);
    logic [ZONE_CNT_W-1:0] n;
    logic [ZONE_CNT_W-1:0] m;
    n = kind ? pcnt : lcnt;
    m = kind ? ZONE_CNT_W'(MAX_PHYSICAL_ZONES) : ZONE_CNT_W'(MAX_LOGICAL_ZONES);
    return (n > m) ? m : n;
  endfunction

  // Reference store address: kind selects the half, then lock_count * zone + lock.
  function automatic logic [REF_AW-1:0] ref_addr(input logic [LOCK_CNT_W-1:0] nlocks,
                                                 input logic                  kind,
                                                 input logic [ZONE_IDX_W-1:0] zone,
                                                 input logic [LOCK_IDX_W-1:0] lock);
    logic [REF_AW-1:0] prod;
    logic [SLOT_W-1:0] slot;
    prod = REF_AW'(nlocks) * REF_AW'(zone);
    slot = prod[SLOT_W-1:0] + SLOT_W'(lock);
    return {kind, slot};
  endfunction

endpackage

FILE: hdl/jlrc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module jlrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/jlrc_update.sv
// Read-modify-write logic: new lock entry, new reference count and the result of one request.
module jlrc_update (
  input  jlrc_pkg::in_t                        req_i,
  input  logic [jlrc_pkg::LOCK_CNT_W-1:0]      nlocks_i,
  input  logic [jlrc_pkg::ZONE_CNT_W-1:0]      nzones_i,
  input  jlrc_pkg::lock_entry_t                entry_i,
  input  logic [jlrc_pkg::COUNT_W-1:0]         ref_i,
  input  logic                                 pending_i,
  output jlrc_pkg::upd_t                       upd_o
);

  jlrc_pkg::lock_entry_t             ent;
  logic [jlrc_pkg::COUNT_W-1:0]      rcnt;
  logic [jlrc_pkg::HOLD_W-1:0]       hold;
  logic [jlrc_pkg::HOLD_W-1:0]       hold_dec;
  logic [jlrc_pkg::COUNT_W-1:0]      jc_dec;
  logic                              lock_ok;
  logic                              zone_ok;
  logic                              note;
  logic                              lock_we;
  logic                              ref_we;
  logic                              clr_pending;
  jlrc_pkg::err_e                    err;
  logic [jlrc_pkg::HOLD_W-1:0]       hold_view;

  always_comb begin
    ent         = entry_i;
    rcnt        = ref_i;
    hold        = req_i.zone_kind ? entry_i.phold : entry_i.lhold;
    hold_dec    = (hold != '0) ? hold - 1'b1 : hold;
    jc_dec      = entry_i.jcount - 1'b1;
    lock_ok     = {1'b0, req_i.lock_index} < nlocks_i;
    zone_ok     = {1'b0, req_i.zone_index} < nzones_i;
    note        = 1'b0;
    lock_we     = 1'b0;
    ref_we      = 1'b0;
    clr_pending = 1'b0;
    err         = jlrc_pkg::ERR_OK;

    if (req_i.command <= jlrc_pkg::CMD_JRELEASE_OTH && !lock_ok) begin
      err = jlrc_pkg::ERR_RANGE;
    end else begin
      unique case (jlrc_pkg::cmd_e'(req_i.command))
        jlrc_pkg::CMD_INIT: begin
          if (entry_i.jcount != entry_i.jdec) begin
            err = jlrc_pkg::ERR_IN_USE;
          end else begin
            ent.jcount = req_i.init_value;
            ent.jdec   = '0;
            lock_we    = 1'b1;
          end
        end
        jlrc_pkg::CMD_ACQUIRE: begin
          if (!zone_ok) begin
            err = jlrc_pkg::ERR_RANGE;
          end else if (ref_i == jlrc_pkg::COUNT_MAX) begin
            err = jlrc_pkg::ERR_OVERFLOW;
          end else begin
            if (ref_i == '0) begin
              if (req_i.zone_kind) begin
                ent.phold = hold + 1'b1;
              end else begin
                ent.lhold = hold + 1'b1;
              end
            end
            rcnt    = ref_i + 1'b1;
            lock_we = 1'b1;
            ref_we  = 1'b1;
          end
        end
        jlrc_pkg::CMD_RELEASE: begin
          if (!zone_ok) begin
            err = jlrc_pkg::ERR_RANGE;
          end else if (ref_i == '0) begin
            err = jlrc_pkg::ERR_UNDERFLOW;
          end else begin
            rcnt   = ref_i - 1'b1;
            ref_we = 1'b1;
            if (rcnt == '0) begin
              if (req_i.zone_kind) begin
                ent.phold = hold_dec;
              end else begin
                ent.lhold = hold_dec;
              end
              lock_we = 1'b1;
              note    = (hold_dec == '0) && !pending_i;
            end
          end
        end
        jlrc_pkg::CMD_JRELEASE: begin
          if (entry_i.jcount <= entry_i.jdec) begin
            err = jlrc_pkg::ERR_UNDERFLOW;
          end else begin
            ent.jcount = jc_dec;
            lock_we    = 1'b1;
            note       = (jc_dec == entry_i.jdec) && !pending_i;
          end
        end
        jlrc_pkg::CMD_JRELEASE_OTH: begin
          if (entry_i.jdec == jlrc_pkg::COUNT_MAX) begin
            err = jlrc_pkg::ERR_OVERFLOW;
          end else begin
            ent.jdec = entry_i.jdec + 1'b1;
            lock_we  = 1'b1;
          end
        end
        jlrc_pkg::CMD_ACK: begin
          clr_pending = 1'b1;
        end
        default: begin
          // Unused command codes change nothing.
        end
      endcase
    end

    hold_view = req_i.zone_kind ? ent.phold : ent.lhold;

    upd_o.lock_we         = lock_we;
    upd_o.ref_we          = ref_we;
    upd_o.lock_wdata      = ent;
    upd_o.ref_wdata       = rcnt;
    upd_o.set_pending     = note;
    upd_o.clr_pending     = clr_pending;
    upd_o.result.locked   = lock_ok && ((ent.jcount != ent.jdec) || (hold_view != '0));
    upd_o.result.notify   = note;
    upd_o.result.error    = err;
  end

endmodule

FILE: hdl/journal_lock_reference_counter_top.sv
// Top level of the journal lock reference counter: control, stores and handshakes.
// A request is accepted only in the idle state; the execute state then completes its
// read-then-write pass over the memories and loads the result into the output register.
// A finished result may wait in the output register while the next request is read.
// After reset the block clears both memories, one entry per cycle up to the last reference
// entry, and accepts no request meanwhile; configuration writes are taken at all times.
module journal_lock_reference_counter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  jlrc_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output jlrc_pkg::out_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [jlrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [jlrc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // Control state.
  jlrc_pkg::state_e                   state_q, state_d;
  logic [jlrc_pkg::REF_AW-1:0]        clr_cnt_q, clr_cnt_d;
  logic                               out_valid_q, out_valid_d;
  logic                               pending_q, pending_d;

  // Payload registers.
  jlrc_pkg::in_t                      req_q;
  jlrc_pkg::out_t                     out_q;

  // Configuration registers.
  logic [jlrc_pkg::LOCK_CNT_W-1:0]    lock_count_q;
  logic [jlrc_pkg::ZONE_CNT_W-1:0]    lzones_q;
  logic [jlrc_pkg::ZONE_CNT_W-1:0]    pzones_q;

  logic [jlrc_pkg::LOCK_CNT_W-1:0]    nlocks;
  logic [jlrc_pkg::ZONE_CNT_W-1:0]    nzones;
  jlrc_pkg::in_t                      rd_req;
  logic                               accept;
  logic                               fire;

  // Memory ports.
  logic                               lock_we;
  logic [jlrc_pkg::LOCK_AW-1:0]       lock_waddr;
  jlrc_pkg::lock_entry_t              lock_wdata;
  logic [jlrc_pkg::LOCK_AW-1:0]       lock_raddr;
  jlrc_pkg::lock_entry_t              lock_rdata;
  logic                               ref_we;
  logic [jlrc_pkg::REF_AW-1:0]        ref_waddr;
  logic [jlrc_pkg::COUNT_W-1:0]       ref_wdata;
  logic [jlrc_pkg::REF_AW-1:0]        ref_raddr;
  logic [jlrc_pkg::COUNT_W-1:0]       ref_rdata;
  logic [jlrc_pkg::REF_AW-1:0]        req_ref_addr;

  jlrc_pkg::upd_t                     upd;

  assign nlocks = jlrc_pkg::eff_locks(lock_count_q);
  assign nzones = jlrc_pkg::eff_zones(req_q.zone_kind, lzones_q, pzones_q);

  // The read address comes straight from the port while idle, so the entry is on the
  // memory outputs in the cycle after acceptance. While a request is held in execution
  // the address follows the captured request and the read data stays put, since nothing
  // is written until the request completes.
  assign rd_req     = (state_q == jlrc_pkg::ST_IDLE) ? in_data_i : req_q;
  assign lock_raddr = rd_req.lock_index;
  assign ref_raddr  = jlrc_pkg::ref_addr(nlocks, rd_req.zone_kind, rd_req.zone_index,
                                         rd_req.lock_index);
  assign req_ref_addr = jlrc_pkg::ref_addr(nlocks, req_q.zone_kind, req_q.zone_index,
                                           req_q.lock_index);

  // Per-lock store: journal count, journal decrements and both holder counts.
  jlrc_ram #(
    .WIDTH ($bits(jlrc_pkg::lock_entry_t)),
    .DEPTH (jlrc_pkg::LOCK_DEPTH)
  ) u_lock_ram (
    .clk_i   (clk_i),
    .we_i    (lock_we),
    .waddr_i (lock_waddr),
    .wdata_i (lock_wdata),
    .raddr_i (lock_raddr),
    .rdata_o (lock_rdata)
  );

  // Reference store: logical zones in the lower half, physical zones in the upper half.
  jlrc_ram #(
    .WIDTH (jlrc_pkg::COUNT_W),
    .DEPTH (jlrc_pkg::REF_DEPTH)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  jlrc_update u_update (
    .req_i     (req_q),
    .nlocks_i  (nlocks),
    .nzones_i  (nzones),
    .entry_i   (lock_rdata),
    .ref_i     (ref_rdata),
    .pending_i (pending_q),
    .upd_o     (upd)
  );

  assign in_stall_o = (state_q != jlrc_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state, memory writes and output register control.
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    pending_d   = pending_q;
    fire        = 1'b0;
    lock_we     = 1'b0;
    lock_waddr  = req_q.lock_index;
    lock_wdata  = upd.lock_wdata;
    ref_we      = 1'b0;
    ref_waddr   = req_ref_addr;
    ref_wdata   = upd.ref_wdata;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      jlrc_pkg::ST_CLEAR: begin
        lock_we    = 1'b1;
        lock_waddr = clr_cnt_q[jlrc_pkg::LOCK_AW-1:0];
        lock_wdata = '0;
        ref_we     = 1'b1;
        ref_waddr  = clr_cnt_q;
        ref_wdata  = '0;
        clr_cnt_d  = clr_cnt_q + 1'b1;
        if (clr_cnt_q == jlrc_pkg::REF_AW'(jlrc_pkg::REF_DEPTH - 1)) begin
          state_d = jlrc_pkg::ST_IDLE;
        end
      end
      jlrc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = jlrc_pkg::ST_EXEC;
        end
      end
      jlrc_pkg::ST_EXEC: begin
        // Complete only once the output register is free or being emptied.
        if (!out_valid_q || !out_stall_i) begin
          fire        = 1'b1;
          lock_we     = upd.lock_we;
          ref_we      = upd.ref_we;
          out_valid_d = 1'b1;
          state_d     = jlrc_pkg::ST_IDLE;
          if (upd.set_pending) begin
            pending_d = 1'b1;
          end else if (upd.clr_pending) begin
            pending_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = jlrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jlrc_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      pending_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      pending_q   <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (fire) begin
      out_q <= upd.result;
    end
  end

  // Configuration registers; a write to an index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_count_q <= jlrc_pkg::LOCK_CNT_W'(jlrc_pkg::MAX_LOCKS);
      lzones_q     <= jlrc_pkg::ZONE_CNT_W'(1);
      pzones_q     <= jlrc_pkg::ZONE_CNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (jlrc_pkg::cfg_idx_e'(cfg_index_i))
        jlrc_pkg::CFG_LOCK_COUNT: begin
          lock_count_q <= cfg_data_i[jlrc_pkg::LOCK_CNT_W-1:0];
        end
        jlrc_pkg::CFG_LOGICAL_ZONES: begin
          lzones_q <= cfg_data_i[jlrc_pkg::ZONE_CNT_W-1:0];
        end
        jlrc_pkg::CFG_PHYSICAL_ZONES: begin
          pzones_q <= cfg_data_i[jlrc_pkg::ZONE_CNT_W-1:0];
        end
        default: begin
          // No register at this index.
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/sv/journal_lock_reference_counter_top_tb.sv
// Self-checking testbench for the journal lock reference counter top level.
`timescale 1ns / 100ps

module journal_lock_reference_counter_top_tb;
  import jlrc_pkg::*;

  // Timing of the run. The limit covers the memory clearing pass after reset and the
  // stalled random phases many times over.
  localparam int          CLK_PERIOD      = 10;
  localparam int          TIMEOUT_NS      = 30_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES   = 8;

  // Zone kinds as carried in the request, and the two command codes the block ignores.
  localparam bit                 LOGICAL      = 1'b0;
  localparam bit                 PHYSICAL     = 1'b1;
  localparam logic [CMD_W-1:0]   CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0]   CMD_SPARE_HI = 3'd7;

  // Tracks the lock table as the block should hold it and checks every result against
  // the outcome predicted for the oldest outstanding request.
  class lock_table_checker;
    logic [COUNT_W-1:0]    jcount   [MAX_LOCKS];
    logic [COUNT_W-1:0]    jdec     [MAX_LOCKS];
    logic [COUNT_W-1:0]    lref     [MAX_LOCKS * MAX_LOGICAL_ZONES];
    logic [COUNT_W-1:0]    pref     [MAX_LOCKS * MAX_PHYSICAL_ZONES];
    logic [HOLD_W-1:0]     lhold    [MAX_LOCKS];
    logic [HOLD_W-1:0]     phold    [MAX_LOCKS];
    bit                    notify_pending;
    logic [LOCK_CNT_W-1:0] lock_cfg;
    logic [ZONE_CNT_W-1:0] lzone_cfg;
    logic [ZONE_CNT_W-1:0] pzone_cfg;
    out_t                  outcomes [$];
    int unsigned           mismatches;
    int unsigned           requests;
    int unsigned           notifications;
    int unsigned           error_tally [8];

    function new();
      foreach (jcount[i]) begin
        jcount[i] = '0;
        jdec[i]   = '0;
        lhold[i]  = '0;
        phold[i]  = '0;
      end
      foreach (lref[i]) lref[i] = '0;
      foreach (pref[i]) pref[i] = '0;
      notify_pending = 1'b0;
      lock_cfg       = LOCK_CNT_W'(256);
      lzone_cfg      = ZONE_CNT_W'(1);
      pzone_cfg      = ZONE_CNT_W'(1);
    endfunction

    function int unsigned lock_limit();
      return (lock_cfg > MAX_LOCKS) ? MAX_LOCKS : int'(lock_cfg);
    endfunction

    function int unsigned zone_limit(input bit kind);
      int unsigned n;
      int unsigned m;
      n = kind ? pzone_cfg : lzone_cfg;
      m = kind ? MAX_PHYSICAL_ZONES : MAX_LOGICAL_ZONES;
      return (n > m) ? m : n;
    endfunction

    function void set_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LOCK_COUNT:     lock_cfg  = data;
        CFG_LOGICAL_ZONES:  lzone_cfg = data[ZONE_CNT_W-1:0];
        CFG_PHYSICAL_ZONES: pzone_cfg = data[ZONE_CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void flag(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t ERROR: %s", $realtime, msg);
    endfunction

    // Applies one accepted request to the table and queues the outcome it must give.
    function void note_request(input in_t req);
      int unsigned        nlocks;
      int unsigned        slot;
      int unsigned        l;
      bit                 lock_ok;
      bit                 raise;
      logic [COUNT_W-1:0] zref;
      logic [HOLD_W-1:0]  holdv;
      err_e               err;
      out_t               want;
      nlocks  = lock_limit();
      l       = req.lock_index;
      lock_ok = req.lock_index < nlocks;
      err     = ERR_OK;
      raise   = 1'b0;
      want    = '0;
      if (!lock_ok && req.command <= CMD_JRELEASE_OTH) begin
        err = ERR_RANGE;
      end else begin
        case (req.command)
          CMD_INIT: begin
            if (jcount[l] != jdec[l]) begin
              err = ERR_IN_USE;
            end else begin
              jcount[l] = req.init_value;
              jdec[l]   = '0;
            end
          end
          CMD_ACQUIRE, CMD_RELEASE: begin
            if (req.zone_index >= zone_limit(req.zone_kind)) begin
              err = ERR_RANGE;
            end else begin
              slot  = nlocks * req.zone_index + req.lock_index;
              zref  = req.zone_kind ? pref[slot] : lref[slot];
              holdv = req.zone_kind ? phold[l] : lhold[l];
              if (req.command == CMD_ACQUIRE) begin
                if (zref == COUNT_MAX) begin
                  err = ERR_OVERFLOW;
                end else begin
                  if (zref == '0) holdv = holdv + 1'b1;
                  zref = zref + 1'b1;
                end
              end else if (zref == '0) begin
                err = ERR_UNDERFLOW;
              end else begin
                zref = zref - 1'b1;
                if (zref == '0) begin
                  if (holdv != '0) holdv = holdv - 1'b1;
                  if (holdv == '0) raise = 1'b1;
                end
              end
              if (req.zone_kind) begin
                pref[slot] = zref;
                phold[l]   = holdv;
              end else begin
                lref[slot] = zref;
                lhold[l]   = holdv;
              end
            end
          end
          CMD_JRELEASE: begin
            if (jcount[l] <= jdec[l]) begin
              err = ERR_UNDERFLOW;
            end else begin
              jcount[l] = jcount[l] - 1'b1;
              if (jcount[l] == jdec[l]) raise = 1'b1;
            end
          end
          CMD_JRELEASE_OTH: begin
            if (jdec[l] == COUNT_MAX) err = ERR_OVERFLOW;
            else jdec[l] = jdec[l] + 1'b1;
          end
          CMD_ACK: notify_pending = 1'b0;
          default: ;
        endcase
      end
      // A notification is only raised when none is already waiting for acknowledge.
      if (raise && !notify_pending) begin
        notify_pending = 1'b1;
        want.notify    = 1'b1;
        notifications++;
      end
      if (lock_ok) begin
        holdv       = req.zone_kind ? phold[l] : lhold[l];
        want.locked = (jcount[l] != jdec[l]) || (holdv != '0);
      end
      want.error = err;
      error_tally[err]++;
      requests++;
      outcomes.push_back(want);
    endfunction

    function void check_outcome(input out_t got);
      out_t want;
      if (outcomes.size() == 0) begin
        flag($sformatf("unexpected result locked=%0b notify=%0b error=%0d",
                       got.locked, got.notify, got.error));
        return;
      end
      want = outcomes.pop_front();
      if (got.locked !== want.locked || got.notify !== want.notify ||
          got.error !== want.error) begin
        flag($sformatf({"expected locked=%0b notify=%0b error=%0d, ",
                        "got locked=%0b notify=%0b error=%0d"},
                       want.locked, want.notify, want.error,
                       got.locked, got.notify, got.error));
      end
    endfunction

    function void close_out();
      if (outcomes.size() != 0)
        flag($sformatf("%0d expected results never arrived", outcomes.size()));
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  lock_table_checker tracker;

  // Idling rates in percent for each side, and the hold-off handshake between the
  // main sequence and the receiver process, which counts the stretch itself.
  int unsigned send_idle_pct     = 0;
  int unsigned recv_idle_pct     = 0;
  int unsigned hold_off_requests = 0;

  journal_lock_reference_counter_top i_dut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Both channels are observed at the clock edge: a request is noted when it is taken,
  // a result is checked when the receiver takes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_request(in_data_i);
      if (out_valid_o && !out_stall_i) tracker.check_outcome(out_data_o);
    end
  end

  // Receiver: stalls at random, or for a long fixed stretch when the main sequence asks,
  // so that the block fills up and has to stall its own input.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned requests_seen;
    hold_left     = 0;
    requests_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_requests != requests_seen) begin
        requests_seen = hold_off_requests;
        hold_left     = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("journal_lock_reference_counter_top test failed");
    $finish;
  end

  // Offers one request, possibly after a few idle cycles, and returns at the edge at
  // which the block takes it. Valid is left high so back-to-back requests need no gap.
  task automatic send_request(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering requests until every outstanding result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outcomes.size() != 0);
  endtask

  // Writes one register; valid stays high so the writes of one setting run back to back.
  task automatic write_register(input cfg_idx_e idx, input int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(idx, CFG_DATA_W'(data));
  endtask

  // New register setting, applied only once the block has gone quiet.
  task automatic configure(input int unsigned locks, input int unsigned lzones,
                           input int unsigned pzones);
    drain();
    write_register(CFG_LOCK_COUNT, locks);
    write_register(CFG_LOGICAL_ZONES, lzones);
    write_register(CFG_PHYSICAL_ZONES, pzones);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_t make_req(input logic [CMD_W-1:0] command, input int unsigned lock,
                                   input bit kind, input int unsigned zone,
                                   input int unsigned value);
    in_t req;
    req.command    = command;
    req.lock_index = LOCK_IDX_W'(lock);
    req.zone_kind  = kind;
    req.zone_index = ZONE_IDX_W'(zone);
    req.init_value = COUNT_W'(value);
    return req;
  endfunction

  // Well-formed requests stay on a handful of locks and on zones in use, with small
  // journal counts, so that acquires, releases and journal releases meet each other
  // and notifications come round. The rest is noise over every field.
  function automatic in_t random_request(input bit well_formed);
    in_t         req;
    int unsigned pick;
    int unsigned pool;
    req = make_req(CMD_W'($urandom_range(7)), $urandom_range(255), 1'($urandom_range(1)),
                   $urandom_range(7), $urandom_range(16'hFFFF));
    if (well_formed) begin
      pool           = (tracker.lock_limit() < 6) ? tracker.lock_limit() : 6;
      req.lock_index = LOCK_IDX_W'($urandom_range(pool - 1));
      req.zone_index = ZONE_IDX_W'($urandom_range(tracker.zone_limit(req.zone_kind) - 1));
      if ($urandom_range(9) != 0) req.init_value = COUNT_W'($urandom_range(4));
      pick = $urandom_range(99);
      if (pick < 10)      req.command = CMD_INIT;
      else if (pick < 35) req.command = CMD_ACQUIRE;
      else if (pick < 60) req.command = CMD_RELEASE;
      else if (pick < 75) req.command = CMD_JRELEASE;
      else if (pick < 85) req.command = CMD_JRELEASE_OTH;
      else                req.command = CMD_ACK;
    end
    return req;
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_request(random_request($urandom_range(99) < 75));
  endtask

  initial begin : sequence_main
    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on a small table: four locks, two logical and three physical zones.
    // The sender idles now and then while the receiver stalls most of the time.
    send_idle_pct = 17;
    recv_idle_pct = 79;
    configure(4, 2, 3);
    send_request(make_req(CMD_ACQUIRE, 0, LOGICAL, 0, 0));
    send_request(make_req(CMD_ACQUIRE, 0, LOGICAL, 1, 0));
    send_request(make_req(CMD_RELEASE, 0, LOGICAL, 0, 0));
    // The last logical holder lets go, which raises the notification.
    send_request(make_req(CMD_RELEASE, 0, LOGICAL, 1, 0));
    send_request(make_req(CMD_RELEASE, 0, LOGICAL, 1, 0));
    // Zone beyond the zones in use, then locks beyond the locks in use.
    send_request(make_req(CMD_ACQUIRE, 0, LOGICAL, 2, 0));
    send_request(make_req(CMD_ACQUIRE, 4, LOGICAL, 0, 0));
    send_request(make_req(CMD_INIT, 255, PHYSICAL, 7, 16'hFFFF));
    send_request(make_req(CMD_INIT, 1, LOGICAL, 0, 3));
    send_request(make_req(CMD_INIT, 1, LOGICAL, 0, 5));
    send_request(make_req(CMD_JRELEASE, 1, LOGICAL, 0, 0));
    send_request(make_req(CMD_JRELEASE_OTH, 1, LOGICAL, 0, 0));
    // The journal count meets its decrements while a notification is still pending.
    send_request(make_req(CMD_JRELEASE, 1, LOGICAL, 0, 0));
    send_request(make_req(CMD_ACK, 200, PHYSICAL, 0, 0));
    send_request(make_req(CMD_INIT, 2, LOGICAL, 0, 1));
    send_request(make_req(CMD_JRELEASE, 2, LOGICAL, 0, 0));
    send_request(make_req(CMD_JRELEASE, 2, LOGICAL, 0, 0));
    send_request(make_req(CMD_ACQUIRE, 3, PHYSICAL, 2, 0));
    send_request(make_req(CMD_ACK, 3, PHYSICAL, 0, 0));
    send_request(make_req(CMD_RELEASE, 3, PHYSICAL, 2, 0));
    send_request(make_req(CMD_ACQUIRE, 3, PHYSICAL, 7, 0));
    send_request(make_req(CMD_INIT, 3, PHYSICAL, 0, 16'hFFFF));
    send_request(make_req(CMD_SPARE_LO, 0, LOGICAL, 0, 0));
    send_request(make_req(CMD_SPARE_HI, 255, PHYSICAL, 7, 16'hFFFF));

    // Random part with the receiver mostly stalled, at the widest and narrowest tables.
    configure(256, 8, 8);
    send_random(120);
    configure(1, 1, 1);
    send_random(100);

    // Now the sender idles most of the time; the second setting runs every count
    // above its limit, where the block must act as if at the limit.
    send_idle_pct = 79;
    recv_idle_pct = 17;
    configure(37, 5, 2);
    send_random(120);
    configure(511, 15, 15);
    send_random(100);

    // No idling at all. The receiver first holds off for a long stretch while the
    // sender keeps offering requests, so the block backs up and stalls its input;
    // later the sender pauses until every result is home.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(8, 8, 8);
    hold_off_requests++;
    send_random(60);
    drain();
    send_random(90);
    configure(256, 3, 8);
    send_random(130);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    tracker.close_out();
    $display("Covered %0d requests over seven register settings, %0d notifications raised.",
             tracker.requests, tracker.notifications);
    $display("Outcomes: ok %0d, overflow %0d, underflow %0d, in use %0d, out of range %0d.",
             tracker.error_tally[ERR_OK], tracker.error_tally[ERR_OVERFLOW],
             tracker.error_tally[ERR_UNDERFLOW], tracker.error_tally[ERR_IN_USE],
             tracker.error_tally[ERR_RANGE]);
    if (tracker.mismatches == 0) begin
      $display("journal_lock_reference_counter_top test passed");
    end else begin
      $display("journal_lock_reference_counter_top test failed");
    end
    $finish;
  end

endmodule
